@@ design/kdph_pkg.sv @@
// ============================================================================
// kdph_pkg - shared types and constants for the key debounce / hold detector
// Holds the phase encoding, event kinds, register indexes and the key
// priority encoder used by the top level and the phase logic.
// ============================================================================
package kdph_pkg;

    localparam int KEY_LINES = 5;
    localparam int CODE_W    = 3;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST  = 8'd4;
    localparam logic [CFG_W-1:0] HOLD_DELAY_RST      = 8'd100;
    localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 8'd200;

    // Event kinds carried on the result channel.
    localparam logic EV_PRESS = 1'b0;
    localparam logic EV_HOLD  = 1'b1;

    localparam logic [CODE_W-1:0] NO_KEY = 3'd0;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_DEBOUNCE = 4'b0010,
        PH_DOWN     = 4'b0100,
        PH_HOLD     = 4'b1000
    } phase_t;

    // Control state that is independent of the counter width.
    typedef struct packed {
        phase_t              phase;
        logic [CODE_W-1:0]   latched_key;
        logic                press_pending;
    } ctrl_t;

    // One result from the phase logic.
    typedef struct packed {
        logic                valid;
        logic                kind;
        logic [CODE_W-1:0]   code;
    } event_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] hold_delay;
        logic [CFG_W-1:0] repeat_interval;
    } cfg_t;

    // Highest-numbered low line wins; line i low gives code i+1.
    function automatic logic [CODE_W-1:0] encode_keys(input logic [KEY_LINES-1:0] lines_n);
        logic [CODE_W-1:0] code;
        code = NO_KEY;
        for (int i = 0; i < KEY_LINES; i++) begin
            if (!lines_n[i]) begin
                code = CODE_W'(i + 1);
            end
        end
        return code;
    endfunction

endpackage

@@ design/kdph_phase_logic.sv @@
// ============================================================================
// kdph_phase_logic - next-state logic for one scan tick
// Encodes the key lines, advances the four-phase controller and its two
// counters, and reports the event that the tick produces, if any.
// ============================================================================
module kdph_phase_logic #(
    parameter int COUNT_BITS = 8
) (
    input  kdph_pkg::cfg_t                    cfg,
    input  logic [kdph_pkg::KEY_LINES-1:0]    key_lines_n,
    input  kdph_pkg::ctrl_t                   ctrl,
    input  logic [COUNT_BITS-1:0]             debounce_count,
    input  logic [COUNT_BITS-1:0]             hold_count,
    output kdph_pkg::ctrl_t                   ctrl_next,
    output logic [COUNT_BITS-1:0]             debounce_count_next,
    output logic [COUNT_BITS-1:0]             hold_count_next,
    output kdph_pkg::event_t                  evt
);

    // Compare at a width that holds both the counter and a register value, so
    // a register value beyond the counter range never matches.
    localparam int CMP_W = (COUNT_BITS > kdph_pkg::CFG_W) ? COUNT_BITS : kdph_pkg::CFG_W;

    logic [kdph_pkg::CODE_W-1:0] code;
    logic [COUNT_BITS-1:0]       debounce_inc;
    logic [COUNT_BITS-1:0]       hold_inc;

    assign code         = kdph_pkg::encode_keys(key_lines_n);
    assign debounce_inc = debounce_count + COUNT_BITS'(1);
    assign hold_inc     = hold_count + COUNT_BITS'(1);

    always_comb begin
        ctrl_next           = ctrl;
        debounce_count_next = debounce_count;
        hold_count_next     = hold_count;
        evt.valid           = 1'b0;
        evt.kind            = kdph_pkg::EV_PRESS;
        evt.code            = ctrl.latched_key;

        unique case (ctrl.phase)
            kdph_pkg::PH_IDLE: begin
                if (ctrl.press_pending) begin
                    // Deliver the latched press; this tick's lines are ignored.
                    evt.valid               = 1'b1;
                    evt.kind                = kdph_pkg::EV_PRESS;
                    ctrl_next.latched_key   = kdph_pkg::NO_KEY;
                    ctrl_next.press_pending = 1'b0;
                end else if (code == kdph_pkg::NO_KEY) begin
                    debounce_count_next = '0;
                end else begin
                    ctrl_next.phase       = kdph_pkg::PH_DEBOUNCE;
                    ctrl_next.latched_key = code;
                end
            end
            kdph_pkg::PH_DEBOUNCE: begin
                if (code != ctrl.latched_key) begin
                    debounce_count_next = '0;
                    ctrl_next.phase     = kdph_pkg::PH_IDLE;
                end else if (CMP_W'(debounce_inc) == CMP_W'(cfg.debounce_ticks)) begin
                    debounce_count_next = '0;
                    ctrl_next.phase     = kdph_pkg::PH_DOWN;
                end else begin
                    debounce_count_next = debounce_inc;
                end
            end
            kdph_pkg::PH_DOWN: begin
                if (code == kdph_pkg::NO_KEY) begin
                    ctrl_next.press_pending = 1'b1;
                    ctrl_next.phase         = kdph_pkg::PH_IDLE;
                    hold_count_next         = '0;
                end else begin
                    ctrl_next.latched_key = code;
                    if (CMP_W'(hold_inc) == CMP_W'(cfg.hold_delay)) begin
                        hold_count_next = '0;
                        ctrl_next.phase = kdph_pkg::PH_HOLD;
                    end else begin
                        hold_count_next = hold_inc;
                    end
                end
            end
            kdph_pkg::PH_HOLD: begin
                if (code == kdph_pkg::NO_KEY) begin
                    hold_count_next         = '0;
                    ctrl_next.press_pending = 1'b0;
                    ctrl_next.phase         = kdph_pkg::PH_IDLE;
                end else if (CMP_W'(hold_inc) == CMP_W'(cfg.repeat_interval)) begin
                    hold_count_next = '0;
                    evt.valid       = 1'b1;
                    evt.kind        = kdph_pkg::EV_HOLD;
                end else begin
                    hold_count_next = hold_inc;
                end
            end
            default: begin
                ctrl_next.phase = kdph_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

@@ design/key_debounce_press_hold_detector_unit.sv @@
// ============================================================================
// key_debounce_press_hold_detector_unit - debounced key press and hold repeat
// Takes one scan tick of five active-low key lines per item and reports short
// presses on release and repeating hold events while a key stays down.
// ============================================================================
//
//  Channel   Direction  Signals                                  Moves
//  --------  ---------  ---------------------------------------  ----------------
//  s_        in         s_valid, s_ready, s_key_lines_n           one scan tick
//  m_        out        m_valid, m_ready, m_event_kind, m_key_code one key event
//  cfg_      in         cfg_wr_en, cfg_index, cfg_wdata           register write
//
// One item is accepted per cycle while s_ready is high. An accepted item is held
// in the input register; the phase logic then updates the state and loads any
// event into the output register, which drives m_valid.
// A result waiting on m_ready holds the input register; s_ready drops once both
// are full. Reset (aresetn low at an edge) returns the controller to idle
// with cleared counters and sets the registers to 4, 100 and 200.
//
module key_debounce_press_hold_detector_unit #(
    parameter int COUNT_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [kdph_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kdph_pkg::CFG_W-1:0]       cfg_wdata,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [kdph_pkg::KEY_LINES-1:0]   s_key_lines_n,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_event_kind,
    output logic [kdph_pkg::CODE_W-1:0]      m_key_code
);

    // Configuration registers.
    kdph_pkg::cfg_t cfg_reg;

    // Input register.
    logic                           in_valid_reg;
    logic [kdph_pkg::KEY_LINES-1:0] in_lines_reg;

    // Controller state.
    kdph_pkg::ctrl_t        ctrl_reg;
    kdph_pkg::ctrl_t        ctrl_next;
    logic [COUNT_BITS-1:0]  debounce_count_reg;
    logic [COUNT_BITS-1:0]  debounce_count_next;
    logic [COUNT_BITS-1:0]  hold_count_reg;
    logic [COUNT_BITS-1:0]  hold_count_next;
    kdph_pkg::event_t       evt;

    // Output register.
    logic                           m_valid_reg;
    logic                           m_event_kind_reg;
    logic [kdph_pkg::CODE_W-1:0]    m_key_code_reg;

    logic advance;

    // The buffered tick is processed whenever the output register can take a
    // possible event, which also frees the input register for a new item.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks  <= kdph_pkg::DEBOUNCE_TICKS_RST;
            cfg_reg.hold_delay      <= kdph_pkg::HOLD_DELAY_RST;
            cfg_reg.repeat_interval <= kdph_pkg::REPEAT_INTERVAL_RST;
        end else if (cfg_wr_en) begin
            // An index beyond the register list is dropped.
            unique case (cfg_index)
                kdph_pkg::REG_DEBOUNCE_TICKS:  cfg_reg.debounce_ticks  <= cfg_wdata;
                kdph_pkg::REG_HOLD_DELAY:      cfg_reg.hold_delay      <= cfg_wdata;
                kdph_pkg::REG_REPEAT_INTERVAL: cfg_reg.repeat_interval <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_lines_reg <= s_key_lines_n;
        end
    end

    kdph_phase_logic #(
        .COUNT_BITS (COUNT_BITS)
    ) u_phase_logic (
        .cfg                 (cfg_reg),
        .key_lines_n         (in_lines_reg),
        .ctrl                (ctrl_reg),
        .debounce_count      (debounce_count_reg),
        .hold_count          (hold_count_reg),
        .ctrl_next           (ctrl_next),
        .debounce_count_next (debounce_count_next),
        .hold_count_next     (hold_count_next),
        .evt                 (evt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.phase         <= kdph_pkg::PH_IDLE;
            ctrl_reg.latched_key   <= kdph_pkg::NO_KEY;
            ctrl_reg.press_pending <= 1'b0;
            debounce_count_reg     <= '0;
            hold_count_reg         <= '0;
        end else if (advance) begin
            ctrl_reg           <= ctrl_next;
            debounce_count_reg <= debounce_count_next;
            hold_count_reg     <= hold_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && evt.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && evt.valid) begin
            m_event_kind_reg <= evt.kind;
            m_key_code_reg   <= evt.code;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = m_event_kind_reg;
    assign m_key_code   = m_key_code_reg;

endmodule
